FILE: hw/rtl/audio_predictor_restore_unit_macros.svh
// Assertion helpers shared by the RTL of the predictor restore unit.
`ifndef AUDIO_PREDICTOR_RESTORE_UNIT_MACROS_SVH
`define AUDIO_PREDICTOR_RESTORE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define APRU_ASSERT_NOW(lbl, c, r, pre, post, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define APRU_ASSERT_NEXT(lbl, c, r, pre, post, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hw/rtl/aprst_pkg.sv
package aprst_pkg;

  // Field widths
  localparam int SAMPLE_W    = 32;
  localparam int COEF_W      = 16;
  localparam int COEF_IDX_W  = 5;
  localparam int POS_W       = 6;
  localparam int ORDER_W     = 6;
  localparam int SHIFT_W     = 4;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 6;

  // Default number of predictor taps (cells in the chain)
  localparam int MAX_ORDER_DEF = 32;

  // Highest fixed polynomial order
  localparam logic [ORDER_W-1:0] FIXED_ORDER_MAX = ORDER_W'(4);

  // Command codes
  localparam logic CMD_COEF   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Predictor modes
  localparam logic MODE_FIXED = 1'b0;
  localparam logic MODE_LPC   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MODE  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_ORDER = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_SHIFT = CFG_ADDR_W'(2);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  // Control group driven from the sequencer into every cell
  typedef struct packed {
    logic                  rotate;   // circulate history and coefficients by one
    logic                  push;     // shift a new sample into the history
    logic                  coef_we;  // load one coefficient
    logic [COEF_IDX_W-1:0] coef_idx;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/aprst_if.sv
// Input channel: coefficient loads and samples/residuals
interface aprst_in_if import aprst_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [COEF_IDX_W-1:0] coeff_index;
  coef_t                 coeff_value;
  sample_t               sample_in;
  logic                  block_start;

  modport source (output valid, cmd, coeff_index, coeff_value, sample_in, block_start,
                  input ready);
  modport sink   (input valid, cmd, coeff_index, coeff_value, sample_in, block_start,
                  output ready);
endinterface

// Result channel: reconstructed samples
interface aprst_out_if import aprst_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

// Configuration write channel
interface aprst_cfg_if import aprst_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/aprst_cell.sv
// One predictor tap: holds one history sample and its coefficient.
module aprst_cell import aprst_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  sample_t    rot_h_in,   // from the next cell (wraps at the tail)
  input  coef_t      rot_c_in,
  input  sample_t    push_h_in,  // from the previous cell or the new result
  input  coef_t      coef_wdata,
  output sample_t    h_out,
  output coef_t      c_out
);

  sample_t h_r;
  coef_t   c_r;
  logic    sel_w;

  assign sel_w = ctrl.coef_we && (ctrl.coef_idx == COEF_IDX_W'(CELL_IDX));

  // History / coefficient storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= '0;
      c_r <= '0;
    end else if (ctrl.rotate) begin
      h_r <= rot_h_in;
      c_r <= rot_c_in;
    end else begin
      if (ctrl.push) begin
        h_r <= push_h_in;
      end
      if (sel_w) begin
        c_r <= coef_wdata;
      end
    end
  end

  assign h_out = h_r;
  assign c_out = c_r;

endmodule

FILE: hw/rtl/aprst_mac.sv
// Shared multiply-accumulate at the head of the cell chain, wraps at 32 bits.
module aprst_mac import aprst_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    clear,
  input  logic    take,
  input  coef_t   coef,
  input  sample_t hist,
  output sample_t acc
);

  logic signed [COEF_W+SAMPLE_W-1:0] full_w;
  logic [SAMPLE_W-1:0] prod_r;
  logic                prod_v_r;
  logic [SAMPLE_W-1:0] acc_r;

  assign full_w = coef * hist;

  // Product register
  always_ff @(posedge clk) begin
    prod_r <= full_w[SAMPLE_W-1:0];
  end

  // Accumulator, adding the registered product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      acc_r    <= '0;
    end else if (clear) begin
      prod_v_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      prod_v_r <= take;
      if (prod_v_r) begin
        acc_r <= acc_r + prod_r;
      end
    end
  end

  assign acc = sample_t'(acc_r);

endmodule

FILE: hw/rtl/audio_predictor_restore_unit.sv
// Coefficient load: no result; the sequencer stays idle, ready for the next item in the following cycle.
// Sample path, accept to out valid: warm-up or pass-through via S_FINISH, fixed via
// S_FIXED and S_FINISH, LPC via S_LPC, S_DRAIN, S_SUM and S_FINISH (history circulates
// once past the single multiply-accumulate). One sample in flight: a new sample is taken
// only back in S_IDLE, later while the result register waits for out ready.
// Synchronous active-low reset clears config, position, history and coefficients.
module audio_predictor_restore_unit import aprst_pkg::*; #(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  aprst_in_if.sink      in_ch,
  aprst_out_if.source   out_ch,
  aprst_cfg_if.sink     cfg_ch
);

  localparam int CNT_W = $clog2(MAX_ORDER);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIXED,
    S_LPC,
    S_DRAIN,
    S_SUM,
    S_FINISH
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [POS_W-1:0]     position_r;
  sample_t              sample_r;
  sample_t              result_r;
  logic                 out_valid_r;
  sample_t              out_data_r;

  logic                 mode_r;
  logic [ORDER_W-1:0]   order_r;
  logic [SHIFT_W-1:0]   shift_r;

  logic                 in_acc_w;
  logic                 is_sample_w;
  logic [ORDER_W-1:0]   order_w;
  logic [POS_W-1:0]     pos_eff_w;
  logic                 out_free_w;
  logic                 mac_clear_w;
  logic                 mac_take_w;
  sample_t              acc_w;
  sample_t              fixed_pred_w;
  cell_ctrl_t           ctrl_w;

  sample_t              h_w [MAX_ORDER];
  coef_t                c_w [MAX_ORDER];

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_FIXED;
      order_r <= '0;
      shift_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_MODE:  mode_r  <= cfg_ch.data[0];
        REG_ORDER: order_r <= cfg_ch.data[ORDER_W-1:0];
        REG_SHIFT: shift_r <= cfg_ch.data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective order and position
  assign order_w   = (order_r > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_r;
  assign pos_eff_w = in_ch.block_start ? '0 : position_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc_w    = in_ch.valid && in_ch.ready;
  assign is_sample_w = (in_ch.cmd == CMD_SAMPLE);
  assign out_free_w  = !out_valid_r || out_ch.ready;

  // Fixed polynomial prediction from the first four cells
  always_comb begin
    case (order_w)
      ORDER_W'(1): fixed_pred_w = h_w[0];
      ORDER_W'(2): fixed_pred_w = (h_w[0] <<< 1) - h_w[1];
      ORDER_W'(3): fixed_pred_w = (h_w[0] <<< 1) + h_w[0] - (h_w[1] <<< 1) - h_w[1]
                                  + h_w[2];
      ORDER_W'(4): fixed_pred_w = (h_w[0] <<< 2) - (h_w[1] <<< 2) - (h_w[1] <<< 1)
                                  + (h_w[2] <<< 2) - h_w[3];
      default:     fixed_pred_w = '0;
    endcase
  end

  // Cell chain control
  assign mac_clear_w = in_acc_w && is_sample_w;
  assign mac_take_w  = (state_r == S_LPC) && (POS_W'(cnt_r) < order_w);

  always_comb begin
    ctrl_w.rotate   = (state_r == S_LPC);
    ctrl_w.push     = (state_r == S_FINISH) && out_free_w;
    ctrl_w.coef_we  = in_acc_w && (in_ch.cmd == CMD_COEF);
    ctrl_w.coef_idx = in_ch.coeff_index;
  end

  // Row of cells: rotate toward the head, push toward the tail
  for (genvar j = 0; j < MAX_ORDER; j++) begin : g_cell
    aprst_cell #(
      .CELL_IDX (j)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl_w),
      .rot_h_in   (h_w[(j + 1) % MAX_ORDER]),
      .rot_c_in   (c_w[(j + 1) % MAX_ORDER]),
      .push_h_in  ((j == 0) ? result_r : h_w[(j + MAX_ORDER - 1) % MAX_ORDER]),
      .coef_wdata (in_ch.coeff_value),
      .h_out      (h_w[j]),
      .c_out      (c_w[j])
    );
  end

  aprst_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (mac_clear_w),
    .take  (mac_take_w),
    .coef  (c_w[0]),
    .hist  (h_w[0]),
    .acc   (acc_w)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      position_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result register: set on push, cleared once taken
      if (ctrl_w.push) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc_w && is_sample_w) begin
            sample_r   <= in_ch.sample_in;
            result_r   <= in_ch.sample_in;
            cnt_r      <= '0;
            position_r <= (pos_eff_w == '1) ? pos_eff_w : pos_eff_w + POS_W'(1);
            if (pos_eff_w < order_w) begin
              state_r <= S_FINISH;
            end else if (mode_r == MODE_LPC) begin
              state_r <= S_LPC;
            end else if (order_w <= FIXED_ORDER_MAX) begin
              state_r <= S_FIXED;
            end else begin
              state_r <= S_FINISH;
            end
          end
        end
        S_FIXED: begin
          result_r <= fixed_pred_w + sample_r;
          state_r  <= S_FINISH;
        end
        S_LPC: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(MAX_ORDER - 1)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_SUM;
        end
        S_SUM: begin
          result_r <= (acc_w >>> shift_r) + sample_r;
          state_r  <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free_w) begin
            out_data_r <= result_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;

`include "audio_predictor_restore_unit_macros.svh"

  `APRU_ASSERT_NEXT(a_coef_no_busy, clk, rst_n, in_acc_w && !is_sample_w,
    state_r == S_IDLE, "coefficient load left the sequencer busy")
  `APRU_ASSERT_NEXT(a_sample_busy, clk, rst_n, in_acc_w && is_sample_w,
    state_r != S_IDLE, "sample accepted without work started")
  `APRU_ASSERT_NEXT(a_lpc_full_turn, clk, rst_n,
    state_r == S_LPC && cnt_r == CNT_W'(MAX_ORDER - 1),
    state_r == S_DRAIN && !ctrl_w.rotate, "chain rotation did not stop after one full turn")
  `APRU_ASSERT_NEXT(a_push_out, clk, rst_n, ctrl_w.push,
    out_valid_r && out_data_r == h_w[0], "history push out of step with the result")
  `APRU_ASSERT_NOW(a_one_move, clk, rst_n, ctrl_w.rotate,
    !ctrl_w.push && !ctrl_w.coef_we, "cell chain asked to rotate and load at once")

endmodule
